// File: rtl/core/atrt_pkg.sv
// Shared types, constants and helpers of the analog threshold relay trigger.
// No dependencies; every other file of the block imports this package.
package atrt_pkg;

  localparam int unsigned SampleBits   = 12;
  localparam int unsigned RelayBits    = 16;
  localparam int unsigned NumWords     = 8;
  localparam int unsigned ChanCount    = 4;
  localparam int unsigned TrigWordBits = 38;
  localparam int unsigned CfgIdxBits   = 3;

  localparam logic [SampleBits-1:0]   NearLimit = 12'd50;
  localparam logic [TrigWordBits-1:0] WordReset = 38'd32768;

  typedef enum logic [1:0] {
    COND_ABOVE = 2'd0,
    COND_BELOW = 2'd1,
    COND_NEAR  = 2'd2,
    COND_NEVER = 2'd3
  } cond_e;

  typedef enum logic [1:0] {
    ACT_OFF    = 2'd0,
    ACT_ON     = 2'd1,
    ACT_TOGGLE = 2'd2,
    ACT_KEEP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TGT_SINGLE = 2'd0,
    TGT_MASK   = 2'd1
  } target_e;

  // trigger word, msb first
  typedef struct packed {
    logic [RelayBits-1:0]  target;
    target_e               tgt_type;
    action_e               action;
    cond_e                 cond;
    logic [SampleBits-1:0] threshold;
    logic [2:0]            channel;
    logic                  enable;
  } trig_word_t;

  typedef struct packed {
    logic [SampleBits-1:0] sample_ch0;
    logic [SampleBits-1:0] sample_ch1;
    logic [SampleBits-1:0] sample_ch2;
    logic [SampleBits-1:0] sample_ch3;
    logic                  relay_load;
    logic [RelayBits-1:0]  relay_load_value;
  } in_item_t;

  typedef struct packed {
    logic [RelayBits-1:0] relay_state;
    logic [NumWords-1:0]  fired_mask;
  } out_item_t;

  // what one trigger does to the relays this tick
  typedef struct packed {
    logic                 hit;
    action_e              action;
    logic [RelayBits-1:0] sel;
  } relay_op_t;

  typedef logic [ChanCount-1:0][SampleBits-1:0] sample_vec_t;

  function automatic logic [RelayBits-1:0] apply_action(
    input logic [RelayBits-1:0] relays,
    input logic [RelayBits-1:0] sel,
    input action_e              action
  );
    logic [RelayBits-1:0] res;
    case (action)
      ACT_OFF:    res = relays & ~sel;
      ACT_ON:     res = relays | sel;
      ACT_TOGGLE: res = relays ^ sel;
      default:    res = relays;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/atrt_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on atrt_pkg for the payload structs.
interface atrt_in_if import atrt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface atrt_out_if import atrt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/atrt_trig_cmp.sv
// One trigger: channel select, threshold compare and relay select mask.
// Depends on atrt_pkg.
module atrt_trig_cmp import atrt_pkg::*; #(
  parameter int unsigned RELAY_COUNT = 16
) (
  input  trig_word_t  word_i,
  input  sample_vec_t samples_i,
  output relay_op_t   op_o
);

  localparam logic [RelayBits-1:0] RelayMask =
    RelayBits'((17'd1 << RELAY_COUNT) - 17'd1);
  localparam logic [7:0] RelayLimit = 8'(RELAY_COUNT);

  logic                  chan_ok;
  logic [SampleBits-1:0] sample;
  logic [SampleBits-1:0] diff;
  logic                  cond_met;
  logic [7:0]            relay_num;

  always_comb begin
    chan_ok = (word_i.channel < 3'(ChanCount));
    case (word_i.channel[1:0])
      2'd0:    sample = samples_i[0];
      2'd1:    sample = samples_i[1];
      2'd2:    sample = samples_i[2];
      default: sample = samples_i[3];
    endcase
    diff = (sample > word_i.threshold) ? sample - word_i.threshold
                                       : word_i.threshold - sample;
    case (word_i.cond)
      COND_ABOVE: cond_met = sample > word_i.threshold;
      COND_BELOW: cond_met = sample < word_i.threshold;
      COND_NEAR:  cond_met = diff < NearLimit;
      COND_NEVER: cond_met = 1'b0;
      default:    cond_met = 1'b0;
    endcase
  end

  always_comb begin
    relay_num     = word_i.target[7:0];
    op_o.hit      = word_i.enable && chan_ok && cond_met;
    op_o.action   = word_i.action;
    op_o.sel      = '0;
    case (word_i.tgt_type)
      TGT_SINGLE: begin
        // relay number past the last relay changes nothing
        if (relay_num < RelayLimit) begin
          op_o.sel = RelayBits'(1) << relay_num[3:0];
        end
      end
      TGT_MASK: op_o.sel = word_i.target & RelayMask;
      default:  op_o.sel = '0;
    endcase
  end

endmodule

// File: rtl/core/analog_threshold_relay_trigger.sv
// Analog threshold relay trigger: takes four ADC samples per transfer and
// updates a 16-bit relay register through up to eight trigger words applied
// in order, each seeing the changes of the ones before it. An optional load
// in the transfer overwrites the relays first. Every input transfer yields
// one result transfer (relay state and fired-trigger mask) via the input and
// result registers; a new item is taken every cycle unless the output stalls,
// the rate set by the relay update between them. The user must write trigger
// words on the cfg port only while no item is in flight; the block does not
// enforce this. Reset disables all words (threshold 2048) and clears relays.
// Depends on atrt_pkg, atrt_if and atrt_trig_cmp.
module analog_threshold_relay_trigger import atrt_pkg::*; #(
  parameter int unsigned TRIGGER_COUNT = 8,
  parameter int unsigned RELAY_COUNT   = 16,
  parameter int unsigned SAMPLE_WIDTH  = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [TrigWordBits-1:0] cfg_data_i,
  atrt_in_if.sink                 in_i,
  atrt_out_if.source              out_o
);

  localparam logic [SampleBits-1:0] SampleMask = (SAMPLE_WIDTH >= SampleBits) ?
    {SampleBits{1'b1}} : SampleBits'((32'd1 << SAMPLE_WIDTH) - 32'd1);
  localparam logic [NumWords-1:0] FiredMask =
    NumWords'((16'd1 << TRIGGER_COUNT) - 16'd1);

  trig_word_t           trig_q [TRIGGER_COUNT];
  relay_op_t            op     [TRIGGER_COUNT];
  in_item_t             in_q;
  logic                 in_valid_q;
  out_item_t            out_q;
  logic                 out_valid_q;
  logic [RelayBits-1:0] relay_q;
  logic [RelayBits-1:0] relay_d;
  logic [NumWords-1:0]  fired_d;
  sample_vec_t          samples;
  logic                 adv;

  // trigger words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TRIGGER_COUNT; k++) trig_q[k] <= trig_word_t'(WordReset);
    end else if (cfg_we_i) begin
      for (int k = 0; k < TRIGGER_COUNT; k++) begin
        if (cfg_idx_i == CfgIdxBits'(k)) trig_q[k] <= trig_word_t'(cfg_data_i);
      end
    end
  end

  // input register stage
  assign adv      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.payload;
  end

  assign samples[0] = in_q.sample_ch0 & SampleMask;
  assign samples[1] = in_q.sample_ch1 & SampleMask;
  assign samples[2] = in_q.sample_ch2 & SampleMask;
  assign samples[3] = in_q.sample_ch3 & SampleMask;

  for (genvar g = 0; g < TRIGGER_COUNT; g++) begin : g_trig
    atrt_trig_cmp #(
      .RELAY_COUNT(RELAY_COUNT)
    ) u_cmp (
      .word_i   (trig_q[g]),
      .samples_i(samples),
      .op_o     (op[g])
    );
  end

  // triggers apply in order on the running relay value
  always_comb begin
    relay_d = in_q.relay_load ? in_q.relay_load_value : relay_q;
    fired_d = '0;
    for (int k = 0; k < TRIGGER_COUNT; k++) begin
      fired_d[k] = op[k].hit;
      if (op[k].hit) relay_d = apply_action(relay_d, op[k].sel, op[k].action);
    end
  end

  // result register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      relay_q     <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        relay_q     <= relay_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.relay_state <= relay_d;
      out_q.fired_mask  <= fired_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // the relay register always matches the last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> relay_q == out_q.relay_state)
    else $error("relay register differs from last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.fired_mask & ~FiredMask) == '0)
    else $error("fired bit set for an unused trigger");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced item did not reach the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q && $stable(in_q) && $stable(relay_q))
    else $error("held item or relay state changed while stalled");

endmodule
